// File: sv/temporal_median_background_top_defines.svh
// assertion macros shared by the rtl files
`ifndef TEMPORAL_MEDIAN_BACKGROUND_TOP_DEFINES_SVH
`define TEMPORAL_MEDIAN_BACKGROUND_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising clock, off during reset
`define TMB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising clock, off during reset
`define TMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// shared types, constants and key arithmetic of the median background block
// ----------------------------------------------------------------------------
`default_nettype none

package tmb_pkg;

    localparam int LIST_DEPTH_DEF  = 15;
    localparam int PIXEL_COUNT_DEF = 65536;

    localparam int ADDR_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int WGT_W   = 4;
    localparam int PROD_W  = CHAN_W + WGT_W;
    localparam int TERM_W  = 9;
    localparam int KEY_W   = 11;
    localparam int CFG_IDX_W = 2;

    // floor(x/10) for x < 4096 as (x*3277) >> 15
    localparam logic [11:0] RECIP10 = 12'd3277;
    localparam int RECIP10_SH = 15;

    localparam logic [PIX_W-1:0] WHITE = {PIX_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = 2'd2;

    localparam logic [WGT_W-1:0] WEIGHT_RED_RST   = 4'd10;
    localparam logic [WGT_W-1:0] WEIGHT_GREEN_RST = 4'd10;
    localparam logic [WGT_W-1:0] WEIGHT_BLUE_RST  = 4'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUOT,
        S_REM,
        S_READ,
        S_PROD,
        S_KEY,
        S_WRITE
    } t_tmb_state;

    typedef struct packed {
        logic load;   // capture list entry and channel products
        logic key;    // reduce products to key
    } t_cell_ctl;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
    } t_prods;

    function automatic logic [TERM_W-1:0] div10(input logic [PROD_W-1:0] x);
        logic [2*PROD_W-1:0] t;
        t = x * RECIP10;
        return t[RECIP10_SH +: TERM_W];
    endfunction

    function automatic t_prods prods_of(input logic [PIX_W-1:0] p,
                                        input logic [WGT_W-1:0] wr,
                                        input logic [WGT_W-1:0] wg,
                                        input logic [WGT_W-1:0] wb);
        t_prods q;
        q.r = p[2*CHAN_W +: CHAN_W] * wr;
        q.g = p[CHAN_W +: CHAN_W] * wg;
        q.b = p[0 +: CHAN_W] * wb;
        return q;
    endfunction

    function automatic logic [KEY_W-1:0] key_of(input t_prods q);
        return KEY_W'(div10(q.r)) + KEY_W'(div10(q.g)) + KEY_W'(div10(q.b));
    endfunction

endpackage

`default_nettype wire

// File: sv/tmb_ram.sv
// ----------------------------------------------------------------------------
// tmb_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: sv/tmb_cell.sv
// ----------------------------------------------------------------------------
// tmb_cell
// one rank of the list: holds its entry and key, decides its new entry
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_cell
    import tmb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_first,
    input  wire logic [WGT_W-1:0] i_wr,
    input  wire logic [WGT_W-1:0] i_wg,
    input  wire logic [WGT_W-1:0] i_wb,
    input  wire logic [PIX_W-1:0] i_rdata,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic [KEY_W-1:0] i_key_in,
    input  wire logic             i_gt_prev,   // some earlier rank is greater
    input  wire logic [PIX_W-1:0] i_entry_prev,
    output logic                  o_gt,
    output logic      [PIX_W-1:0] o_entry,
    output logic      [PIX_W-1:0] o_new
);

    logic [PIX_W-1:0] r_entry;
    t_prods           r_prods;
    logic [KEY_W-1:0] r_key;
    logic [PIX_W-1:0] n_entry;
    logic             gt;

    always_comb begin
        n_entry = i_first ? WHITE : i_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= n_entry;
            r_prods <= prods_of(n_entry, i_wr, i_wg, i_wb);
        end
        if (i_ctl.key) begin
            r_key <= key_of(r_prods);
        end
    end

    always_comb begin
        gt = r_key > i_key_in;
        o_gt = i_gt_prev | gt;
        o_entry = r_entry;
        if (i_gt_prev) begin
            o_new = i_entry_prev;   // shifted down one rank
        end else if (gt) begin
            o_new = i_pixel;        // insert point
        end else begin
            o_new = r_entry;
        end
    end

endmodule

`default_nettype wire

// File: sv/temporal_median_background_top.sv
// ----------------------------------------------------------------------------
// temporal_median_background_top
// per-pixel temporal median over a batch of frames, one rank list per pixel
// ----------------------------------------------------------------------------
// usage
//   pulse start with a pixel (address, rgb, first/last frame flags) while
//   busy is low; the transfer happens at that clock edge
//   each item runs through the states in order: S_QUOT and S_REM reduce
//   the address modulo the frame size, S_READ reads all rank banks,
//   S_PROD and S_KEY form the luminance keys, S_WRITE compares and writes
//   back; the next item is taken only after the write-back, set by the
//   read-modify-write of the per-pixel rank banks and two-step key multiply
//   with last_frame set, the median entry appears on the median ports for
//   one cycle with o_median_valid, the cycle after the write-back
//   the receiver cannot stall; a result is offered exactly once
//   weights are written on the cfg port while busy is low
//   reset clears the sequencer, sets default weights; rank banks are not
//   cleared, a list holds defined data only after a first-frame pixel
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_median_background_top_defines.svh"

module temporal_median_background_top
    import tmb_pkg::*;
#(
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [ADDR_W-1:0]    i_pixel_address,
    input  wire logic [CHAN_W-1:0]    i_red_in,
    input  wire logic [CHAN_W-1:0]    i_green_in,
    input  wire logic [CHAN_W-1:0]    i_blue_in,
    input  wire logic                 i_first_frame,
    input  wire logic                 i_last_frame,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WGT_W-1:0]     i_cfg_data,
    output logic                      o_median_valid,
    output logic      [ADDR_W-1:0]    o_median_address,
    output logic      [CHAN_W-1:0]    o_median_red,
    output logic      [CHAN_W-1:0]    o_median_green,
    output logic      [CHAN_W-1:0]    o_median_blue
);

    localparam int POS_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int RAM_D   = (PIXEL_COUNT > 1) ? PIXEL_COUNT : 2;
    localparam int MID     = LIST_DEPTH / 2;
    // floor(2^32 / PIXEL_COUNT); quotient estimate is low by at most one
    localparam longint RECIP_L = (64'd1 << 32) / PIXEL_COUNT;
    localparam int RECIP_W = 33;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PC_W    = 21;
    localparam logic [PC_W-1:0] PC = PC_W'(PIXEL_COUNT);

    t_tmb_state r_state, n_state;

    // latched item
    logic [ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_first;
    logic              r_last;

    // weights
    logic [WGT_W-1:0] r_wr, r_wg, r_wb;

    // address reduction
    logic [ADDR_W-1:0] r_quot;
    logic [POS_W-1:0]  r_pos;
    logic [ADDR_W+RECIP_W-1:0] quot_prod;
    logic [ADDR_W+PC_W-1:0]    back_prod;
    logic [ADDR_W:0]           rem_raw;
    logic [ADDR_W:0]           rem_fix;

    // incoming pixel key
    t_prods           r_in_prods;
    logic [KEY_W-1:0] r_in_key;

    t_cell_ctl cell_ctl;
    logic      ram_we;

    logic [PIX_W-1:0] rdata     [LIST_DEPTH];
    logic [PIX_W-1:0] entry     [LIST_DEPTH];
    logic [PIX_W-1:0] new_entry [LIST_DEPTH];
    logic             gt_chain  [LIST_DEPTH+1];
    logic [PIX_W-1:0] entry_prev[LIST_DEPTH];

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        cell_ctl = '0;
        ram_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT:  n_state = S_REM;
            S_REM:   n_state = S_READ;
            S_READ:  n_state = S_PROD;
            S_PROD: begin
                cell_ctl.load = 1'b1;
                n_state = S_KEY;
            end
            S_KEY: begin
                cell_ctl.key = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // ---- item capture and weights ----
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_addr  <= i_pixel_address;
            r_pixel <= {i_red_in, i_green_in, i_blue_in};
            r_first <= i_first_frame;
            r_last  <= i_last_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= WEIGHT_RED_RST;
            r_wg <= WEIGHT_GREEN_RST;
            r_wb <= WEIGHT_BLUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WEIGHT_RED:   r_wr <= i_cfg_data;
                REG_WEIGHT_GREEN: r_wg <= i_cfg_data;
                REG_WEIGHT_BLUE:  r_wb <= i_cfg_data;
                default: ;        // unused index, write dropped
            endcase
        end
    end

    // ---- pixel position = address modulo frame size ----
    always_comb begin
        quot_prod = r_addr * RECIP;
        back_prod = r_quot * PC;
        rem_raw   = {1'b0, r_addr} - (ADDR_W+1)'(back_prod);
        // compare at full frame-size width, frame sizes below 2^21 never wrap
        rem_fix   = (PC_W'(rem_raw) >= PC) ?
                    rem_raw - (ADDR_W+1)'(PC) : rem_raw;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_QUOT) begin
            r_quot <= quot_prod[32 +: ADDR_W];
        end
        if (r_state == S_REM) begin
            r_pos <= POS_W'(rem_fix);
        end
        // incoming key follows the same two steps as the cells
        if (cell_ctl.load) begin
            r_in_prods <= prods_of(r_pixel, r_wr, r_wg, r_wb);
        end
        if (cell_ctl.key) begin
            r_in_key <= key_of(r_in_prods);
        end
    end

    // ---- rank banks and cell row ----
    assign gt_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_rank
            tmb_ram #(
                .WIDTH (PIX_W),
                .DEPTH (RAM_D)
            ) u_bank (
                .i_clk   (i_clk),
                .i_we    (ram_we),
                .i_addr  ($clog2(RAM_D)'(r_pos)),
                .i_wdata (new_entry[gi]),
                .o_rdata (rdata[gi])
            );

            if (gi == 0) begin : g_head
                assign entry_prev[gi] = r_pixel;   // never selected at rank 0
            end else begin : g_body
                assign entry_prev[gi] = entry[gi-1];
            end

            tmb_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_first      (r_first),
                .i_wr         (r_wr),
                .i_wg         (r_wg),
                .i_wb         (r_wb),
                .i_rdata      (rdata[gi]),
                .i_pixel      (r_pixel),
                .i_key_in     (r_in_key),
                .i_gt_prev    (gt_chain[gi]),
                .i_entry_prev (entry_prev[gi]),
                .o_gt         (gt_chain[gi+1]),
                .o_entry      (entry[gi]),
                .o_new        (new_entry[gi])
            );
        end
    endgenerate

    // ---- result register, median is the new middle rank ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_median_valid <= 1'b0;
        end else begin
            o_median_valid <= ram_we && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            o_median_address <= r_addr;
            o_median_red     <= new_entry[MID][2*CHAN_W +: CHAN_W];
            o_median_green   <= new_entry[MID][CHAN_W +: CHAN_W];
            o_median_blue    <= new_entry[MID][0 +: CHAN_W];
        end
    end

    // ---- checks ----
    `TMB_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy && r_state == S_QUOT, "start not taken")
    `TMB_ASSERT_NOW(a_result_after_write, o_median_valid, $past(r_state) == S_WRITE, "stray result")
    `TMB_ASSERT_NEXT(a_write_ends_item, r_state == S_WRITE, !busy, "item did not finish")
    `TMB_ASSERT_NOW(a_pos_in_range, r_state == S_READ, r_pos <= POS_W'(PIXEL_COUNT - 1), "bad pos")

endmodule

`default_nettype wire
